FILE: hw/rtl/lje_pkg.sv
package lje_pkg;

  // Table size and derived widths
  localparam int MAX_ATOMS = 256;
  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CW = $clog2(MAX_ATOMS + 1);

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  // Input opcodes
  localparam logic [0:0] OP_LOAD = 1'b0;
  localparam logic [0:0] OP_EVAL = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_REPULSIVE  = 3'd0;
  localparam logic [2:0] CFG_ATTRACTIVE = 3'd1;
  localparam logic [2:0] CFG_SHIFT      = 3'd2;
  localparam logic [2:0] CFG_COUNT      = 3'd3;

  // Adder: aligned sum, before normalization
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sgn;
    logic signed [11:0] ex;
    logic [50:0]        mag;
  } add_s1_t;

  // Multiplier: raw product, before normalization
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sgn;
    logic signed [11:0] ex;
    logic [47:0]        prod;
  } mul_s1_t;

  // Round to nearest even and pack. Value is sig * 2^(e-49), sig[49] set.
  function automatic logic [31:0] fp_pack(logic s, logic signed [11:0] e, logic [49:0] sig);
    logic signed [11:0] be;
    logic signed [11:0] sh12;
    logic [5:0]         sh;
    logic [49:0]        work;
    logic [7:0]         ef;
    logic [23:0]        mant;
    logic               inc;
    logic [24:0]        m25;
    logic [31:0]        r;
    be = e + 12'sd127;
    work = sig;
    ef = 8'd0;
    if (be >= 12'sd255) begin
      return {s, 8'hFF, 23'd0};
    end
    if (be >= 12'sd1) begin
      ef = 8'(be - 12'sd1);
    end else begin
      // subnormal result: shift out with sticky
      sh12 = 12'sd1 - be;
      sh = (sh12 > 12'sd50) ? 6'd50 : sh12[5:0];
      work = sig >> sh;
      work[0] = work[0] | (|(sig & ~({50{1'b1}} << sh)));
    end
    mant = work[49:26];
    inc = work[25] & ((|work[24:0]) | mant[0]);
    m25 = {1'b0, mant} + {24'd0, inc};
    // mantissa carry ripples into the exponent field
    r = {1'b0, ef, 23'd0} + {7'd0, m25};
    return {s, r[30:0]};
  endfunction

  function automatic add_s1_t fp_add_pre(logic [31:0] a, logic [31:0] b);
    add_s1_t     r;
    logic [31:0] big;
    logic [31:0] sml;
    logic        nan_a;
    logic        nan_b;
    logic        inf_a;
    logic        inf_b;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [23:0] mb;
    logic [23:0] ms;
    logic [7:0]  diff;
    logic [50:0] av;
    logic [50:0] bv;
    logic [50:0] bsh;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (a[30:0] == 31'h7F80_0000);
    inf_b = (b[30:0] == 31'h7F80_0000);
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mb = {big[30:23] != 8'd0, big[22:0]};
    ms = {sml[30:23] != 8'd0, sml[22:0]};
    diff = eb - es;
    av = {1'b0, mb, 26'd0};
    bv = {1'b0, ms, 26'd0};
    // align the smaller operand, sticky into the lsb
    if (diff > 8'd50) begin
      bsh = {50'd0, |ms};
    end else begin
      bsh = bv >> diff;
      bsh[0] = bsh[0] | (|(bv & ~({51{1'b1}} << diff)));
    end
    r.mag = (big[31] == sml[31]) ? (av + bsh) : (av - bsh);
    r.sgn = big[31];
    r.ex = $signed({4'd0, eb}) - 12'sd176;
    r.spec = 1'b0;
    r.spec_val = 32'd0;
    if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
      r.spec = 1'b1;
      r.spec_val = QNAN;
    end else if (inf_a) begin
      r.spec = 1'b1;
      r.spec_val = a;
    end else if (inf_b) begin
      r.spec = 1'b1;
      r.spec_val = b;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      r.spec = 1'b1;
      r.spec_val = {a[31] & b[31], 31'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_add_post(add_s1_t x);
    logic [5:0]  p;
    logic [49:0] sig;
    p = 6'd0;
    for (int i = 0; i < 51; i++) begin
      if (x.mag[i]) p = 6'(i);
    end
    if (x.spec) return x.spec_val;
    if (x.mag == 51'd0) return 32'd0;
    if (p == 6'd50) begin
      sig = {x.mag[50:2], x.mag[1] | x.mag[0]};
    end else begin
      sig = x.mag[49:0] << (6'd49 - p);
    end
    return fp_pack(x.sgn, x.ex + $signed({6'd0, p}), sig);
  endfunction

  function automatic mul_s1_t fp_mul_pre(logic [31:0] a, logic [31:0] b);
    mul_s1_t            r;
    logic               nan_a;
    logic               nan_b;
    logic               inf_a;
    logic               inf_b;
    logic               zer_a;
    logic               zer_b;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic signed [11:0] ea;
    logic signed [11:0] eb;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (a[30:0] == 31'h7F80_0000);
    inf_b = (b[30:0] == 31'h7F80_0000);
    zer_a = (a[30:0] == 31'd0);
    zer_b = (b[30:0] == 31'd0);
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    ea = $signed({4'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]}) - 12'sd127;
    eb = $signed({4'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}) - 12'sd127;
    r.sgn = a[31] ^ b[31];
    r.prod = ma * mb;
    r.ex = ea + eb - 12'sd46;
    r.spec = 1'b0;
    r.spec_val = 32'd0;
    if (nan_a || nan_b || (inf_a && zer_b) || (inf_b && zer_a)) begin
      r.spec = 1'b1;
      r.spec_val = QNAN;
    end else if (inf_a || inf_b) begin
      r.spec = 1'b1;
      r.spec_val = {a[31] ^ b[31], 8'hFF, 23'd0};
    end else if (zer_a || zer_b) begin
      r.spec = 1'b1;
      r.spec_val = {a[31] ^ b[31], 31'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_mul_post(mul_s1_t x);
    logic [5:0]  q;
    logic [49:0] sig;
    q = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (x.prod[i]) q = 6'(i);
    end
    if (x.spec) return x.spec_val;
    sig = {x.prod, 2'b00} << (6'd47 - q);
    return fp_pack(x.sgn, x.ex + $signed({6'd0, q}), sig);
  endfunction

endpackage

FILE: hw/rtl/lennard_jones_energy_sum_top.sv
// Lennard-Jones 12-6 energy sum over a table of up to 256 centres, all in IEEE
// single precision. A load (opcode 0) writes one centre and gives no result. An
// evaluate (opcode 1) walks the first atom_count centres through one shared float
// adder, one shared float multiplier and a radix-2 reciprocal unit; an evaluate
// holds busy until its energy is ready, and the energy is on energy_o in the
// cycle that follows. A micro-step sequencer reuses these units. The energy
// appears on energy_o for exactly one cycle with valid_o; the receiver cannot
// stall it, so it must take the result in that cycle. Registers are written over
// the cfg channel, which is always ready; the user must write them only while
// busy is low, as the block itself does not enforce it.
module lennard_jones_energy_sum_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [0:0]  opcode_i,
  input  logic [7:0]  slot_i,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [31:0] coord_z_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        valid_o,
  output logic [31:0] energy_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WB    = 4'b0100,
    S_DIV   = 4'b1000
  } state_e;

  typedef enum logic [3:0] {
    SRC_PX, SRC_PY, SRC_PZ, SRC_CX, SRC_CY, SRC_CZ,
    SRC_TA, SRC_TB, SRC_TC, SRC_U, SRC_C12, SRC_C6, SRC_SHIFT
  } src_e;

  typedef enum logic [2:0] {DST_TA, DST_TB, DST_TC, DST_U, DST_RES} dst_e;
  typedef enum logic [1:0] {K_ADD, K_MUL, K_DIV} kind_e;

  typedef struct packed {
    src_e  a;
    src_e  b;
    logic  negb;
    kind_e kind;
    dst_e  dst;
  } uop_t;

  localparam logic [4:0] STEP_LAST  = 5'd15;
  localparam logic [4:0] STEP_FINAL = 5'd16;
  localparam logic [4:0] DIV_ITERS  = 5'd26;

  // Micro-steps for one centre, then the final shift
  function automatic uop_t ucode(logic [4:0] st);
    uop_t u;
    u = '{a: SRC_TA, b: SRC_TA, negb: 1'b0, kind: K_ADD, dst: DST_TA};
    case (st)
      5'd0:  u = '{SRC_PX, SRC_CX, 1'b1, K_ADD, DST_TA};
      5'd1:  u = '{SRC_PY, SRC_CY, 1'b1, K_ADD, DST_TB};
      5'd2:  u = '{SRC_PZ, SRC_CZ, 1'b1, K_ADD, DST_TC};
      5'd3:  u = '{SRC_TA, SRC_TA, 1'b0, K_MUL, DST_TA};
      5'd4:  u = '{SRC_TB, SRC_TB, 1'b0, K_MUL, DST_TB};
      5'd5:  u = '{SRC_TC, SRC_TC, 1'b0, K_MUL, DST_TC};
      5'd6:  u = '{SRC_TA, SRC_TB, 1'b0, K_ADD, DST_TA};
      5'd7:  u = '{SRC_TA, SRC_TC, 1'b0, K_ADD, DST_TA};
      5'd8:  u = '{SRC_TA, SRC_TA, 1'b0, K_DIV, DST_TA};
      5'd9:  u = '{SRC_TA, SRC_TA, 1'b0, K_MUL, DST_TB};
      5'd10: u = '{SRC_TB, SRC_TA, 1'b0, K_MUL, DST_TA};
      5'd11: u = '{SRC_C12, SRC_TA, 1'b0, K_MUL, DST_TB};
      5'd12: u = '{SRC_TB, SRC_TA, 1'b0, K_MUL, DST_TB};
      5'd13: u = '{SRC_C6, SRC_TA, 1'b0, K_MUL, DST_TC};
      5'd14: u = '{SRC_TB, SRC_TC, 1'b1, K_ADD, DST_TA};
      5'd15: u = '{SRC_U, SRC_TA, 1'b0, K_ADD, DST_U};
      5'd16: u = '{SRC_U, SRC_SHIFT, 1'b1, K_ADD, DST_RES};
      default: u = '{SRC_TA, SRC_TA, 1'b0, K_ADD, DST_TA};
    endcase
    return u;
  endfunction

  state_e state_q, state_d;
  logic [4:0]  step_q, step_d;
  logic [lje_pkg::CW-1:0] idx_q, idx_d, num_q, num_d;
  logic [31:0] c12_q, c6_q, shift_q;
  logic [8:0]  count_q;
  logic [31:0] px_q, py_q, pz_q, ta_q, tb_q, tc_q, u_q;
  logic [31:0] px_d, py_d, pz_d;
  logic        valid_q, valid_d;
  logic [31:0] energy_q;

  lje_pkg::add_s1_t add_s1_q;
  lje_pkg::mul_s1_t mul_s1_q;

  // Reciprocal unit
  logic [24:0] drem_q;
  logic [23:0] dm_q;
  logic [25:0] dquo_q;
  logic [4:0]  dcnt_q;
  logic signed [11:0] dex_q;
  logic        dsgn_q, dspec_q;
  logic [31:0] dspec_val_q;
  logic        div_load;

  logic [95:0] rdata;
  logic        ram_we, ram_re;
  logic [lje_pkg::AW-1:0] ram_raddr;
  logic [lje_pkg::CW-1:0] idx_next;

  uop_t        uop;
  logic [31:0] op_a, op_b, wb_val, div_res;
  logic        wb_en;
  logic [lje_pkg::CW-1:0] n_eff;

  assign uop = ucode(step_q);
  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign valid_o = valid_q;
  assign energy_o = energy_q;
  assign idx_next = idx_q + lje_pkg::CW'(1);

  // Clamp the centre count to the table size
  assign n_eff = (32'(count_q) > 32'(lje_pkg::MAX_ATOMS)) ?
                 lje_pkg::CW'(lje_pkg::MAX_ATOMS) : lje_pkg::CW'(count_q);

  // Operand select
  function automatic logic [31:0] pick(src_e s, logic [31:0] px, logic [31:0] py,
                                       logic [31:0] pz, logic [95:0] c, logic [31:0] ta,
                                       logic [31:0] tb, logic [31:0] tc, logic [31:0] u,
                                       logic [31:0] c12, logic [31:0] c6,
                                       logic [31:0] sh);
    logic [31:0] v;
    case (s)
      SRC_PX:    v = px;
      SRC_PY:    v = py;
      SRC_PZ:    v = pz;
      SRC_CX:    v = c[31:0];
      SRC_CY:    v = c[63:32];
      SRC_CZ:    v = c[95:64];
      SRC_TA:    v = ta;
      SRC_TB:    v = tb;
      SRC_TC:    v = tc;
      SRC_U:     v = u;
      SRC_C12:   v = c12;
      SRC_C6:    v = c6;
      SRC_SHIFT: v = sh;
      default:   v = ta;
    endcase
    return v;
  endfunction

  always_comb begin
    op_a = pick(uop.a, px_q, py_q, pz_q, rdata, ta_q, tb_q, tc_q, u_q, c12_q, c6_q, shift_q);
    op_b = pick(uop.b, px_q, py_q, pz_q, rdata, ta_q, tb_q, tc_q, u_q, c12_q, c6_q, shift_q);
    op_b[31] = op_b[31] ^ uop.negb;
  end

  // Centre table, x in the low word
  assign ram_we = (state_q == S_IDLE) && start && (opcode_i == lje_pkg::OP_LOAD) &&
                  (32'(slot_i) < 32'(lje_pkg::MAX_ATOMS));

  lje_ram #(
    .WIDTH(96),
    .DEPTH(lje_pkg::MAX_ATOMS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(lje_pkg::AW'(slot_i)),
    .wdata_i({coord_z_i, coord_y_i, coord_x_i}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  // Reciprocal result: normalize quotient and round
  always_comb begin
    logic [49:0] sig;
    logic        lz;
    lz = ~dquo_q[25];
    sig = {dquo_q, 23'd0, drem_q != 25'd0};
    if (lz) sig = {sig[48:1], 1'b0, sig[0]};
    if (dspec_q) begin
      div_res = dspec_val_q;
    end else begin
      div_res = lje_pkg::fp_pack(dsgn_q, -dex_q - $signed({11'd0, lz}), sig);
    end
  end

  // Reciprocal unit: one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (div_load) begin
      logic [23:0] ma;
      logic [4:0]  lz;
      lz = 5'd0;
      ma = {op_a[30:23] != 8'd0, op_a[22:0]};
      for (int i = 0; i < 24; i++) begin
        if (ma[i]) lz = 5'(23 - i);
      end
      dm_q <= ma << lz;
      dex_q <= $signed({4'd0, (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23]}) - 12'sd127
               - $signed({7'd0, lz});
      dsgn_q <= op_a[31];
      drem_q <= 25'd1 << 23;
      dquo_q <= 26'd0;
      dcnt_q <= DIV_ITERS;
      dspec_q <= 1'b1;
      if ((op_a[30:23] == 8'hFF) && (op_a[22:0] != 23'd0)) begin
        dspec_val_q <= lje_pkg::QNAN;
      end else if (op_a[30:0] == 31'd0) begin
        dspec_val_q <= {op_a[31], 8'hFF, 23'd0};
      end else if (op_a[30:23] == 8'hFF) begin
        dspec_val_q <= {op_a[31], 31'd0};
      end else begin
        dspec_q <= 1'b0;
        dspec_val_q <= 32'd0;
      end
    end else if (dcnt_q != 5'd0) begin
      if (drem_q >= {1'b0, dm_q}) begin
        drem_q <= (drem_q - {1'b0, dm_q}) << 1;
        dquo_q <= {dquo_q[24:0], 1'b1};
      end else begin
        drem_q <= drem_q << 1;
        dquo_q <= {dquo_q[24:0], 1'b0};
      end
      dcnt_q <= dcnt_q - 5'd1;
    end
  end

  // First stage of the adder and multiplier
  always_ff @(posedge clk_i) begin
    if (state_q == S_ISSUE) begin
      add_s1_q <= lje_pkg::fp_add_pre(op_a, op_b);
      mul_s1_q <= lje_pkg::fp_mul_pre(op_a, op_b);
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d = step_q;
    idx_d = idx_q;
    num_d = num_q;
    px_d = px_q;
    py_d = py_q;
    pz_d = pz_q;
    valid_d = 1'b0;
    ram_re = 1'b0;
    ram_raddr = lje_pkg::AW'(0);
    div_load = 1'b0;
    wb_en = 1'b0;
    wb_val = (uop.kind == K_MUL) ? lje_pkg::fp_mul_post(mul_s1_q) :
             lje_pkg::fp_add_post(add_s1_q);
    case (state_q)
      S_IDLE: begin
        if (start && (opcode_i == lje_pkg::OP_EVAL)) begin
          px_d = coord_x_i;
          py_d = coord_y_i;
          pz_d = coord_z_i;
          idx_d = '0;
          num_d = n_eff;
          ram_re = 1'b1;
          step_d = (n_eff == '0) ? STEP_FINAL : 5'd0;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (uop.kind == K_DIV) begin
          div_load = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        wb_en = 1'b1;
        state_d = S_ISSUE;
        if (step_q == STEP_FINAL) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else if (step_q == STEP_LAST) begin
          idx_d = idx_next;
          if (idx_next == num_q) begin
            step_d = STEP_FINAL;
          end else begin
            ram_re = 1'b1;
            ram_raddr = idx_next[lje_pkg::AW-1:0];
            step_d = 5'd0;
          end
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      S_DIV: begin
        wb_val = div_res;
        if (dcnt_q == 5'd0) begin
          wb_en = 1'b1;
          step_d = step_q + 5'd1;
          state_d = S_ISSUE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q <= 5'd0;
      idx_q <= '0;
      num_q <= '0;
      valid_q <= 1'b0;
      c12_q <= 32'd0;
      c6_q <= 32'd0;
      shift_q <= 32'd0;
      count_q <= 9'd0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      idx_q <= idx_d;
      num_q <= num_d;
      valid_q <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          lje_pkg::CFG_REPULSIVE:  c12_q <= cfg_data_i;
          lje_pkg::CFG_ATTRACTIVE: c6_q <= cfg_data_i;
          lje_pkg::CFG_SHIFT:      shift_q <= cfg_data_i;
          lje_pkg::CFG_COUNT:      count_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
    pz_q <= pz_d;
    if ((state_q == S_IDLE) && start && (opcode_i == lje_pkg::OP_EVAL)) begin
      u_q <= 32'd0;
    end
    if (wb_en) begin
      case (uop.dst)
        DST_TA:  ta_q <= wb_val;
        DST_TB:  tb_q <= wb_val;
        DST_TC:  tc_q <= wb_val;
        DST_U:   u_q <= wb_val;
        DST_RES: energy_q <= wb_val;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/lje_ram.sv
module lje_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // index outside the register map, writes must be dropped
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam logic [31:0] FP_ONE = 32'h3F80_0000;
  localparam logic [31:0] FP_POS_INF = 32'h7F80_0000;
  localparam logic [31:0] FP_NEG_INF = 32'hFF80_0000;
  localparam logic [31:0] FP_MAX = 32'h7F7F_FFFF;
  localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;
  localparam int ITEM_TARGET = 1900;
  localparam int CYCLE_LIMIT = 4_000_000;

  // ---------------------------------------------------------------
  // Energy predictor and result store
  // ---------------------------------------------------------------
  class energy_scoreboard;
    logic [31:0] c12;
    logic [31:0] c6;
    logic [31:0] shift_val;
    logic [8:0]  n_atoms;
    logic [31:0] cx [lje_pkg::MAX_ATOMS];
    logic [31:0] cy [lje_pkg::MAX_ATOMS];
    logic [31:0] cz [lje_pkg::MAX_ATOMS];
    logic [31:0] energy_q [$];
    int          n_errors;

    function new();
      c12 = '0;
      c6 = '0;
      shift_val = '0;
      n_atoms = '0;
      n_errors = 0;
      for (int i = 0; i < lje_pkg::MAX_ATOMS; i++) begin
        cx[i] = '0;
        cy[i] = '0;
        cz[i] = '0;
      end
    endfunction

    static function bit is_nan(logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    static function bit is_inf(logic [31:0] a);
      return a[30:0] == 31'h7F80_0000;
    endfunction

    static function bit is_zero(logic [31:0] a);
      return a[30:0] == 31'd0;
    endfunction

    // finite value = m * 2^e
    static function void split(input logic [31:0] a, output logic [63:0] m, output int e);
      if (a[30:23] == 8'd0) begin
        m = {41'd0, a[22:0]};
        e = -149;
      end else begin
        m = {40'd0, 1'b1, a[22:0]};
        e = int'(a[30:23]) - 150;
      end
    endfunction

    // round to nearest even, value = m * 2^e, m nonzero
    static function logic [31:0] round_pack(bit s, int e, logic [63:0] m);
      int           p;
      int           sh;
      int           qe;
      logic [127:0] w;
      logic [127:0] rem;
      logic [127:0] half;
      logic [24:0]  mant;
      p = 0;
      for (int i = 0; i < 64; i++) if (m[i]) p = i;
      sh = p - 23;
      if (-149 - e > sh) sh = -149 - e;
      w = {64'd0, m};
      if (sh <= 0) begin
        mant = 25'(w << (-sh));
      end else if (sh > 100) begin
        mant = '0;
      end else begin
        mant = 25'(w >> sh);
        rem = w & ((128'd1 << sh) - 128'd1);
        half = 128'd1 << (sh - 1);
        if (rem > half || (rem == half && mant[0])) mant = mant + 25'd1;
      end
      qe = e + sh;
      if (mant[24]) begin
        mant = mant >> 1;
        qe = qe + 1;
      end
      if (mant[23]) begin
        if (qe + 150 >= 255) return {s, 8'hFF, 23'd0};
        return {s, 8'(qe + 150), mant[22:0]};
      end
      return {s, 8'd0, mant[22:0]};
    endfunction

    static function logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] big;
      logic [63:0] sml;
      logic [63:0] tmp;
      int          ea;
      int          eb;
      int          diff;
      bit          sb;
      bit          ss;
      if (is_nan(a) || is_nan(b)) return lje_pkg::QNAN;
      if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : lje_pkg::QNAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
      if (is_zero(a)) return b;
      if (is_zero(b)) return a;
      split(a, ma, ea);
      split(b, mb, eb);
      if (ea >= eb) begin
        big = ma; sml = mb; sb = a[31]; ss = b[31]; diff = ea - eb;
      end else begin
        big = mb; sml = ma; sb = b[31]; ss = a[31]; diff = eb - ea;
        ea = eb;
      end
      big = big << 38;
      // align the smaller operand, keep a sticky bit
      if (diff >= 62) begin
        sml = 64'd1;
      end else begin
        tmp = sml << 38;
        sml = (tmp >> diff) | 64'(|(tmp & ((64'd1 << diff) - 64'd1)));
      end
      if (sb == ss) return round_pack(sb, ea - 38, big + sml);
      if (big > sml) return round_pack(sb, ea - 38, big - sml);
      if (sml > big) return round_pack(ss, ea - 38, sml - big);
      return 32'd0;
    endfunction

    static function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      int          ea;
      int          eb;
      if (is_nan(a) || is_nan(b)) return lje_pkg::QNAN;
      if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) return lje_pkg::QNAN;
      if (is_inf(a) || is_inf(b)) return {a[31] ^ b[31], 8'hFF, 23'd0};
      if (is_zero(a) || is_zero(b)) return {a[31] ^ b[31], 31'd0};
      split(a, ma, ea);
      split(b, mb, eb);
      return round_pack(a[31] ^ b[31], ea + eb, ma * mb);
    endfunction

    // 1/d
    static function logic [31:0] frecip(logic [31:0] d);
      logic [63:0] md;
      logic [63:0] q;
      logic [63:0] r;
      int          ed;
      if (is_nan(d)) return lje_pkg::QNAN;
      if (is_inf(d)) return {d[31], 31'd0};
      if (is_zero(d)) return {d[31], 8'hFF, 23'd0};
      split(d, md, ed);
      q = (64'd1 << 62) / md;
      r = (64'd1 << 62) % md;
      return round_pack(d[31], -63 - ed, (q << 1) | 64'(r != 64'd0));
    endfunction

    function logic [31:0] pair_energy(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                      int i);
      logic [31:0] dx;
      logic [31:0] dy;
      logic [31:0] dz;
      logic [31:0] d2;
      logic [31:0] s;
      logic [31:0] t;
      dx = fadd(px, cx[i] ^ 32'h8000_0000);
      dy = fadd(py, cy[i] ^ 32'h8000_0000);
      dz = fadd(pz, cz[i] ^ 32'h8000_0000);
      d2 = fadd(fadd(fmul(dx, dx), fmul(dy, dy)), fmul(dz, dz));
      s = frecip(d2);
      t = fmul(fmul(s, s), s);
      return fadd(fmul(fmul(c12, t), t), fmul(c6, t) ^ 32'h8000_0000);
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        lje_pkg::CFG_REPULSIVE:  c12 = data;
        lje_pkg::CFG_ATTRACTIVE: c6 = data;
        lje_pkg::CFG_SHIFT:      shift_val = data;
        lje_pkg::CFG_COUNT:      n_atoms = data[8:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [0:0] op, logic [7:0] slot, logic [31:0] x,
                            logic [31:0] y, logic [31:0] z);
      logic [31:0] u;
      int          n;
      if (op == lje_pkg::OP_LOAD) begin
        cx[slot] = x;
        cy[slot] = y;
        cz[slot] = z;
        return;
      end
      n = (n_atoms > lje_pkg::MAX_ATOMS) ? lje_pkg::MAX_ATOMS : int'(n_atoms);
      u = 32'd0;
      for (int i = 0; i < n; i++) u = fadd(u, pair_energy(x, y, z, i));
      energy_q.push_back(fadd(u, shift_val ^ 32'h8000_0000));
    endfunction

    function void check_energy(logic [31:0] got);
      logic [31:0] want;
      if (energy_q.size() == 0) begin
        $error("unexpected result: energy %h", got);
        n_errors++;
        return;
      end
      want = energy_q.pop_front();
      if (got !== want) begin
        $error("energy mismatch: expected %h actual %h", want, got);
        n_errors++;
      end
    endfunction

    function int pending();
      return energy_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------
  // DUT and clocking
  // ---------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [0:0]  opcode_i;
  logic [7:0]  slot_i;
  logic [31:0] coord_x_i;
  logic [31:0] coord_y_i;
  logic [31:0] coord_z_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        valid_o;
  logic [31:0] energy_o;

  lennard_jones_energy_sum_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .slot_i      (slot_i),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .coord_z_i   (coord_z_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .valid_o     (valid_o),
    .energy_o    (energy_o)
  );

  energy_scoreboard sb;
  int              n_sent;
  bit              allow_idle;
  bit              loaded [lje_pkg::MAX_ATOMS];
  logic [31:0]     tab_x [lje_pkg::MAX_ATOMS];
  logic [31:0]     tab_y [lje_pkg::MAX_ATOMS];
  logic [31:0]     tab_z [lje_pkg::MAX_ATOMS];
  longint          cycles;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // result monitor, results cannot be held off
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_energy(energy_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(0, 15))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 6))
          0: v = 32'd0;
          1: v = FP_NEG_ZERO;
          2: v = FP_POS_INF;
          3: v = FP_NEG_INF;
          4: v = 32'h7FC0_0000 | 32'($urandom_range(0, 255));
          5: v = 32'd1;
          default: v = FP_MAX;
        endcase
      end
      2: v = {1'($urandom), 8'd0, 23'($urandom)};
      default: v = {1'($urandom), 8'($urandom_range(123, 131)), 23'($urandom)};
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'd0;
      2: return rand_coord();
      default: return {($urandom_range(0, 7) == 0), 8'($urandom_range(122, 130)),
                       23'($urandom)};
    endcase
  endfunction

  function automatic int written_prefix();
    int p;
    p = 0;
    while (p < lje_pkg::MAX_ATOMS && loaded[p]) p++;
    return p;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_item(logic [0:0] op, logic [7:0] slot, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z);
    if (allow_idle && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk_i);
    start = 1'b1;
    opcode_i = op;
    slot_i = slot;
    coord_x_i = x;
    coord_y_i = y;
    coord_z_i = z;
    do @(posedge clk_i); while (busy);
    sb.note_item(op, slot, x, y, z);
    if (op == lje_pkg::OP_LOAD) begin
      loaded[slot] = 1'b1;
      tab_x[slot] = x;
      tab_y[slot] = y;
      tab_z[slot] = z;
    end
    n_sent++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // block idle: results in, then a margin for a load still in flight
  task automatic wait_drained();
    while (sb.pending() > 0) @(negedge clk_i);
    repeat (70) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic random_eval(int n_live);
    int k;
    if (n_live > 0 && $urandom_range(0, 7) == 0) begin
      // probe on top of a centre
      k = $urandom_range(0, n_live - 1);
      send_item(lje_pkg::OP_EVAL, 8'($urandom), tab_x[k], tab_y[k], tab_z[k]);
    end else begin
      send_item(lje_pkg::OP_EVAL, 8'($urandom), rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    int          phase;
    int          n_live;
    int          n_items;
    logic [8:0]  count;
    sb = new();
    cycles = 0;
    n_sent = 0;
    allow_idle = 1'b1;
    for (int i = 0; i < lje_pkg::MAX_ATOMS; i++) loaded[i] = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    opcode_i = lje_pkg::OP_LOAD;
    slot_i = '0;
    coord_x_i = '0;
    coord_y_i = '0;
    coord_z_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: basic energies, coinciding probe, special operands
    write_reg(lje_pkg::CFG_REPULSIVE, FP_ONE);
    write_reg(lje_pkg::CFG_ATTRACTIVE, 32'h4000_0000);
    write_reg(lje_pkg::CFG_SHIFT, 32'hBF80_0000);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    write_reg(lje_pkg::CFG_COUNT, 32'd4);
    send_item(lje_pkg::OP_LOAD, 8'd0, 32'd0, 32'd0, 32'd0);
    send_item(lje_pkg::OP_LOAD, 8'd1, FP_ONE, 32'd0, 32'd0);
    send_item(lje_pkg::OP_LOAD, 8'd2, 32'd0, 32'hBFC0_0000, FP_NEG_ZERO);
    send_item(lje_pkg::OP_LOAD, 8'd3, 32'd1, FP_NEG_ZERO, FP_MAX);
    send_item(lje_pkg::OP_LOAD, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(lje_pkg::OP_LOAD, 8'd128, FP_POS_INF, FP_NEG_INF, 32'd0);
    send_item(lje_pkg::OP_EVAL, 8'd0, 32'h4000_0000, 32'd0, 32'd0);
    send_item(lje_pkg::OP_EVAL, 8'hFF, 32'd0, 32'd0, 32'd0);
    send_item(lje_pkg::OP_EVAL, 8'd0, 32'h7FC0_0001, 32'd0, 32'd0);
    send_item(lje_pkg::OP_EVAL, 8'd0, FP_NEG_INF, FP_ONE, FP_ONE);
    send_item(lje_pkg::OP_EVAL, 8'd0, FP_NEG_ZERO, FP_NEG_ZERO, FP_NEG_ZERO);
    send_item(lje_pkg::OP_EVAL, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(lje_pkg::OP_EVAL, 8'd0, FP_MAX, 32'h8000_0001, 32'h3F00_0000);
    wait_drained();
    // empty sum
    write_reg(lje_pkg::CFG_COUNT, 32'd0);
    write_reg(lje_pkg::CFG_SHIFT, 32'h4040_0000);
    send_item(lje_pkg::OP_EVAL, 8'd0, FP_ONE, FP_ONE, FP_ONE);
    wait_drained();

    // random phases, each with its own register setting
    phase = 0;
    while (n_sent < ITEM_TARGET) begin
      if (phase == 3) count = 9'd256;
      else if (phase == 7) count = 9'h1FF;
      else if ($urandom_range(0, 5) == 0) count = 9'd1;
      else count = 9'($urandom_range(0, 12));
      n_live = (count > lje_pkg::MAX_ATOMS) ? lje_pkg::MAX_ATOMS : int'(count);
      write_reg(lje_pkg::CFG_REPULSIVE, rand_coeff());
      write_reg(lje_pkg::CFG_ATTRACTIVE, rand_coeff());
      write_reg(lje_pkg::CFG_SHIFT, rand_coeff());
      write_reg(lje_pkg::CFG_COUNT, 32'(count));
      // fill the table up to the summed range first
      for (int s = written_prefix(); s < n_live; s++)
        send_item(lje_pkg::OP_LOAD, 8'(s), rand_coord(), rand_coord(), rand_coord());
      n_items = (n_live > 32) ? 3 : 120;
      for (int i = 0; i < n_items; i++) begin
        if (n_sent > ITEM_TARGET - 250) allow_idle = 1'b0;
        if (n_live > 32 || $urandom_range(0, 1) == 0) begin
          random_eval(n_live);
        end else begin
          send_item(lje_pkg::OP_LOAD, 8'($urandom), rand_coord(), rand_coord(),
                    rand_coord());
        end
        // hold the sender until the pipeline is empty, once in phase 1
        if (i == 40 && phase == 1) while (sb.pending() > 0) @(negedge clk_i);
      end
      wait_drained();
      phase++;
    end

    wait_drained();
    if (sb.n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
